// ===== rtl/ewse_pkg.sv =====
// ============================================================================
// ewse_pkg
// Shared types and constants of the encoder window speed estimator.
// ============================================================================
package ewse_pkg;

    // field widths
    localparam int ANGLE_W  = 13;
    localparam int GAP_W    = 5;
    localparam int SUM_W    = 11;
    localparam int ENTRY_W  = ANGLE_W + GAP_W;
    localparam int GAIN_W   = 24;
    localparam int THR_W    = 24;
    localparam int GEAR_W   = 16;
    localparam int TMO_W    = 5;
    localparam int SPEED_W  = 32;
    localparam int DIR_W    = 2;
    localparam int DVD_W    = ANGLE_W + GAIN_W;
    localparam int PROD_W   = SPEED_W + GEAR_W;

    // APB register map
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam logic [2:0] REG_RATE_GAIN  = 3'd0;
    localparam logic [2:0] REG_ENTER_THR  = 3'd1;
    localparam logic [2:0] REG_LEAVE_THR  = 3'd2;
    localparam logic [2:0] REG_GEAR_SCALE = 3'd3;
    localparam logic [2:0] REG_TIMEOUT    = 3'd4;

    // register reset values
    localparam logic [GAIN_W-1:0]        RATE_GAIN_RST  = 24'd50266;
    localparam logic [THR_W-1:0]         ENTER_THR_RST  = 24'd9830;
    localparam logic [THR_W-1:0]         LEAVE_THR_RST  = 24'd0;
    localparam logic signed [GEAR_W-1:0] GEAR_SCALE_RST = 16'sd4096;
    localparam logic [TMO_W-1:0]         TIMEOUT_RST    = 5'd25;

    // angle wrap and gear scaling
    localparam logic signed [ANGLE_W:0]   WRAP_LIMIT = 14'sd6000;
    localparam logic signed [ANGLE_W+1:0] WRAP_SPAN  = 15'sd8192;
    localparam int GEAR_SHIFT = 12;
    localparam logic signed [PROD_W-1:0] GEAR_RND = PROD_W'((1 << GEAR_SHIFT) - 1);

    localparam logic [SPEED_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
    localparam logic [SPEED_W-1:0] SPEED_MIN = 32'h8000_0000;

    // rotation codes
    localparam logic [DIR_W-1:0] ROT_STOP = 2'd0;
    localparam logic [DIR_W-1:0] ROT_CW   = 2'd1;
    localparam logic [DIR_W-1:0] ROT_CCW  = 2'd2;

    typedef struct packed {
        logic [GAIN_W-1:0]        rate_gain;
        logic [THR_W-1:0]         enter_threshold;
        logic [THR_W-1:0]         leave_threshold;
        logic signed [GEAR_W-1:0] gear_scale;
        logic [TMO_W-1:0]         timeout_ticks;
    } cfg_t;

endpackage

// ===== rtl/ewse_regs.sv =====
// ============================================================================
// ewse_regs
// APB configuration registers of the speed estimator.
// ============================================================================
module ewse_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ewse_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ewse_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ewse_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output ewse_pkg::cfg_t                  cfg
);
    import ewse_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    // write registers on the access beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rate_gain       <= RATE_GAIN_RST;
            cfg_reg.enter_threshold <= ENTER_THR_RST;
            cfg_reg.leave_threshold <= LEAVE_THR_RST;
            cfg_reg.gear_scale      <= GEAR_SCALE_RST;
            cfg_reg.timeout_ticks   <= TIMEOUT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RATE_GAIN:  cfg_reg.rate_gain       <= pwdata[GAIN_W-1:0];
                REG_ENTER_THR:  cfg_reg.enter_threshold <= pwdata[THR_W-1:0];
                REG_LEAVE_THR:  cfg_reg.leave_threshold <= pwdata[THR_W-1:0];
                REG_GEAR_SCALE: cfg_reg.gear_scale      <= signed'(pwdata[GEAR_W-1:0]);
                REG_TIMEOUT:    cfg_reg.timeout_ticks   <= pwdata[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            REG_RATE_GAIN:  prdata = {8'd0, cfg_reg.rate_gain};
            REG_ENTER_THR:  prdata = {8'd0, cfg_reg.enter_threshold};
            REG_LEAVE_THR:  prdata = {8'd0, cfg_reg.leave_threshold};
            REG_GEAR_SCALE: prdata = {{16{cfg_reg.gear_scale[GEAR_W-1]}}, cfg_reg.gear_scale};
            REG_TIMEOUT:    prdata = {27'd0, cfg_reg.timeout_ticks};
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== rtl/ewse_ring.sv =====
// ============================================================================
// ewse_ring
// Sample ring memory: angle and tick gap per slot, registered read.
// ============================================================================
module ewse_ring #(
    parameter int DEPTH  = 50,
    parameter int ADDR_W = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [ewse_pkg::ENTRY_W-1:0]  rd_data,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [ewse_pkg::ENTRY_W-1:0]  wr_data
);
    import ewse_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic               rd_valid_reg;

    // storage array
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // per-entry valid bits, so unwritten slots read as zero after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/ewse_div.sv =====
// ============================================================================
// ewse_div
// Restoring serial divider, one quotient bit per cycle.
// ============================================================================
module ewse_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ewse_pkg::DVD_W-1:0]   dividend,
    input  logic [ewse_pkg::SUM_W-1:0]   divisor,
    output logic                         busy,
    output logic [ewse_pkg::DVD_W-1:0]   quotient
);
    import ewse_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [SUM_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [SUM_W:0]   rem_sh;
    logic [SUM_W:0]   rem_sub;
    logic             ge;

    // shift in one dividend bit, try the subtract
    assign rem_sh  = {rem_reg, quo_reg[DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign ge      = rem_sh >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
            quo_next  = {quo_reg[DVD_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/encoder_window_speed_estimator.sv =====
// ============================================================================
// encoder_window_speed_estimator
// Windowed encoder speed estimate with direction detection and link timeout.
// ============================================================================
// Sequence: a fresh-sample beat passes READ, MUL, the 37-step serial divider,
// DIR, GEAR and DONE before its result; a no-sample beat goes straight to DONE.
// A new beat is taken only once the last result has reached the output
// register and the sequencer is back in IDLE.
// Reset: synchronous, active low; clears control state, ring valid bits and
// restores register defaults.
module encoder_window_speed_estimator #(
    parameter int RING_DEPTH = 50
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [12:0] angle_count, [15:13] zero
    input  logic [0:0]  s_tuser,   // [0] fresh
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] speed, [33:32] direction,
                                   // [34] not_connected, [39:35] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ewse_pkg::*;

    localparam int SLOT_W = $clog2(RING_DEPTH);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_READ = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_DIR  = 7'b0010000,
        ST_GEAR = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    cfg_t cfg;

    state_t                   state_reg, state_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic [GAP_W-1:0]         tick_reg, tick_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [DIR_W-1:0]         rot_reg, rot_next;
    logic [SPEED_W-1:0]       held_reg, held_next;
    logic                     lost_reg, lost_next;
    logic                     mvalid_reg, mvalid_next;
    logic [39:0]              mdata_reg, mdata_next;

    logic [ANGLE_W-1:0]       angle_reg;
    logic                     neg_reg, neg_next;
    logic [ANGLE_W-1:0]       mag_reg, mag_next;
    logic signed [SPEED_W-1:0] est_reg, est_next;
    logic signed [PROD_W-1:0] gprod_reg, gprod_next;

    logic                     s_acc;
    logic                     ring_rd;
    logic                     ring_wr;
    logic [ENTRY_W-1:0]       ring_q;
    logic [ANGLE_W-1:0]       old_angle;
    logic [GAP_W-1:0]         old_gap;
    logic signed [ANGLE_W:0]  diff_raw;
    logic signed [ANGLE_W:0]  diff_wr;
    logic [TMO_W:0]           tick_inc;
    logic                     div_start;
    logic                     div_busy;
    logic [DVD_W-1:0]         div_q;
    logic [DVD_W-1:0]         dvd;
    logic signed [SPEED_W:0]  est_x;
    logic signed [SPEED_W:0]  enter_x;
    logic signed [SPEED_W:0]  leave_x;
    logic signed [PROD_W-1:0] gprod_adj;
    logic [PROD_W-GEAR_SHIFT-1:0] gear_q;
    logic                     gear_fits;

    // configuration registers
    ewse_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sample ring
    ewse_ring #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (ring_rd),
        .rd_addr (slot_reg),
        .rd_data (ring_q),
        .wr_en   (ring_wr),
        .wr_addr (slot_reg),
        .wr_data ({angle_reg, tick_reg})
    );

    // window divider
    ewse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (sum_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid & s_tready;
    assign ring_rd   = s_acc & s_tuser[0];
    assign ring_wr   = (state_reg == ST_READ);
    assign div_start = (state_reg == ST_MUL);
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;

    // old ring entry and wrapped angle difference
    assign old_angle = ring_q[ENTRY_W-1:GAP_W];
    assign old_gap   = ring_q[GAP_W-1:0];
    assign diff_raw  = signed'({1'b0, angle_reg}) - signed'({1'b0, old_angle});
    always_comb begin
        if (diff_raw > WRAP_LIMIT) begin
            diff_wr = (ANGLE_W+1)'(diff_raw - WRAP_SPAN);
        end else if (diff_raw < -WRAP_LIMIT) begin
            diff_wr = (ANGLE_W+1)'(diff_raw + WRAP_SPAN);
        end else begin
            diff_wr = diff_raw;
        end
    end

    assign tick_inc = {1'b0, tick_reg} + 1'b1;
    assign dvd      = DVD_W'(mag_reg * cfg.rate_gain);

    // direction compares and gear rounding toward zero
    assign est_x     = {est_reg[SPEED_W-1], est_reg};
    assign enter_x   = signed'({9'd0, cfg.enter_threshold});
    assign leave_x   = signed'({9'd0, cfg.leave_threshold});
    assign gprod_adj = gprod_reg + (gprod_reg[PROD_W-1] ? GEAR_RND : '0);
    assign gear_q    = gprod_adj[PROD_W-1:GEAR_SHIFT];
    assign gear_fits = (&gear_q[PROD_W-GEAR_SHIFT-1:SPEED_W-1])
                     | ~(|gear_q[PROD_W-GEAR_SHIFT-1:SPEED_W-1]);

    // sequencer
    always_comb begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        tick_next   = tick_reg;
        sum_next    = sum_reg;
        rot_next    = rot_reg;
        held_next   = held_reg;
        lost_next   = lost_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        est_next    = est_reg;
        gprod_next  = gprod_reg;

        // retire the held beat
        if (m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser[0]) begin
                        state_next = ST_READ;
                    end else begin
                        // count the idle tick, flag a timeout
                        if (tick_inc > {1'b0, cfg.timeout_ticks}) begin
                            lost_next = 1'b1;
                            tick_next = GAP_W'(1);
                        end else begin
                            tick_next = tick_inc[GAP_W-1:0];
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ: begin
                // update gap sum, store new entry, advance slot
                sum_next  = sum_reg + SUM_W'(tick_reg) - SUM_W'(old_gap);
                neg_next  = diff_wr[ANGLE_W];
                mag_next  = diff_wr[ANGLE_W] ? ANGLE_W'(-diff_wr) : ANGLE_W'(diff_wr);
                slot_next = (slot_reg == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                tick_next = GAP_W'(1);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!div_busy) begin
                    if (sum_reg == '0) begin
                        if (neg_reg) begin
                            est_next = signed'(SPEED_MIN);
                        end else if (mag_reg == '0) begin
                            est_next = '0;
                        end else begin
                            est_next = signed'(SPEED_MAX);
                        end
                    end else if (|div_q[DVD_W-1:SPEED_W-1]) begin
                        est_next = neg_reg ? signed'(SPEED_MIN) : signed'(SPEED_MAX);
                    end else if (neg_reg) begin
                        est_next = signed'(SPEED_W'(-{1'b0, div_q[SPEED_W-2:0]}));
                    end else begin
                        est_next = signed'({1'b0, div_q[SPEED_W-2:0]});
                    end
                    state_next = ST_DIR;
                end
            end
            ST_DIR: begin
                // hysteresis direction detector
                case (rot_reg)
                    ROT_STOP: begin
                        if (est_x > enter_x) begin
                            rot_next = ROT_CCW;
                        end else if (est_x < -enter_x) begin
                            rot_next = ROT_CW;
                        end
                    end
                    ROT_CW: begin
                        if (est_x > leave_x) begin
                            rot_next = ROT_STOP;
                        end
                    end
                    ROT_CCW: begin
                        if (est_x < -leave_x) begin
                            rot_next = ROT_STOP;
                        end
                    end
                    default: ;
                endcase
                gprod_next = est_reg * cfg.gear_scale;
                state_next = ST_GEAR;
            end
            ST_GEAR: begin
                if (gear_fits) begin
                    held_next = gear_q[SPEED_W-1:0];
                end else begin
                    held_next = gear_q[PROD_W-GEAR_SHIFT-1] ? SPEED_MIN : SPEED_MAX;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hand the result to the output register once it is free
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {5'd0, lost_reg, rot_reg, held_reg};
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            slot_reg   <= '0;
            tick_reg   <= '0;
            sum_reg    <= '0;
            rot_reg    <= ROT_STOP;
            held_reg   <= '0;
            lost_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            slot_reg   <= slot_next;
            tick_reg   <= tick_next;
            sum_reg    <= sum_next;
            rot_reg    <= rot_next;
            held_reg   <= held_next;
            lost_reg   <= lost_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (ring_rd) begin
            angle_reg <= s_tdata[ANGLE_W-1:0];
        end
        mdata_reg <= mdata_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        est_reg   <= est_next;
        gprod_reg <= gprod_next;
    end

    // divider runs only while the sequencer waits on it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside divide state");

    // ring slot stays inside the ring
    assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_W'(RING_DEPTH - 1))
        else $error("ring slot out of range");

    // every handled beat leaves a nonzero tick gap
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (tick_reg != '0))
        else $error("tick gap zero after a beat");

    // the ring is written in the cycle after a fresh beat is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        ring_rd |=> ring_wr)
        else $error("ring write did not follow read");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: encoder window speed estimator testbench
// Drives control ticks into the estimator over the input stream, predicts the
// geared speed, rotation state and link flag of every tick, and compares each
// result beat with the oldest prediction. Registers are rewritten between
// phases over APB while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ewse_pkg::*;

    localparam int         RING_DEPTH      = 50;
    localparam longint     SAT_HI          = 64'sd2147483647;
    localparam longint     SAT_LO          = -64'sd2147483648;
    localparam int         WATCHDOG_LIMIT  = 3000;
    localparam int         MAX_SHOWN       = 10;
    localparam int         N_PHASES        = 10;
    localparam int         ITEMS_PER_PHASE = 90;
    localparam logic [2:0] REG_UNUSED      = 3'd7;

    typedef struct {
        logic [31:0] speed;
        logic [1:0]  direction;
        logic        not_connected;
    } reading_t;

    // Tracks estimator state and the readings still owed by the block.
    class speed_scoreboard;
        cfg_t        cfg;
        logic [12:0] angle_ring [RING_DEPTH];
        logic [4:0]  gap_ring [RING_DEPTH];
        logic [10:0] gap_sum;
        int          ring_slot;
        logic [4:0]  tick_gap;
        logic [1:0]  rotation;
        logic [31:0] held_speed;
        logic        lost_link;
        reading_t    expected_readings[$];
        int          errors;

        function new();
            cfg.rate_gain       = RATE_GAIN_RST;
            cfg.enter_threshold = ENTER_THR_RST;
            cfg.leave_threshold = LEAVE_THR_RST;
            cfg.gear_scale      = GEAR_SCALE_RST;
            cfg.timeout_ticks   = TIMEOUT_RST;
            for (int i = 0; i < RING_DEPTH; i++) begin
                angle_ring[i] = '0;
                gap_ring[i]   = '0;
            end
            gap_sum    = '0;
            ring_slot  = 0;
            tick_gap   = '0;
            rotation   = ROT_STOP;
            held_speed = '0;
            lost_link  = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] word);
            case (idx)
                REG_RATE_GAIN:  cfg.rate_gain       = word[23:0];
                REG_ENTER_THR:  cfg.enter_threshold = word[23:0];
                REG_LEAVE_THR:  cfg.leave_threshold = word[23:0];
                REG_GEAR_SCALE: cfg.gear_scale      = word[15:0];
                REG_TIMEOUT:    cfg.timeout_ticks   = word[4:0];
                default: ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > SAT_HI) return SAT_HI;
            if (v < SAT_LO) return SAT_LO;
            return v;
        endfunction

        // Advance the estimator by one tick and queue the reading it yields.
        function void predict_tick(bit fresh, logic [12:0] angle);
            int       slot;
            int       next_tick;
            longint   diff, est, gain, enter, leave, gear;
            reading_t r;
            if (fresh) begin
                slot = ring_slot;
                gap_sum = gap_sum + 11'(tick_gap) - 11'(gap_ring[slot]);
                diff = longint'(angle) - longint'(angle_ring[slot]);
                if (diff > WRAP_LIMIT) diff = diff - WRAP_SPAN;
                else if (diff < -WRAP_LIMIT) diff = diff + WRAP_SPAN;

                // window rate; an empty gap sum pins to the extreme of the sign
                gain = cfg.rate_gain;
                if (gap_sum == 0) begin
                    if (diff > 0) est = SAT_HI;
                    else if (diff < 0) est = SAT_LO;
                    else est = 0;
                end else begin
                    est = clamp32((diff * gain) / longint'(gap_sum));
                end

                // hysteresis on the ungeared estimate
                enter = cfg.enter_threshold;
                leave = cfg.leave_threshold;
                if (rotation == ROT_STOP) begin
                    if (est > enter) rotation = ROT_CCW;
                    else if (est < -enter) rotation = ROT_CW;
                end else if ((rotation == ROT_CW && est > leave) ||
                             (rotation == ROT_CCW && est < -leave)) begin
                    rotation = ROT_STOP;
                end

                gear = $signed(cfg.gear_scale);
                held_speed = 32'(clamp32((est * gear) / (longint'(1) << GEAR_SHIFT)));

                angle_ring[slot] = angle;
                gap_ring[slot]   = tick_gap;
                slot++;
                if (slot >= RING_DEPTH) slot = 0;
                ring_slot = slot;
                tick_gap  = 5'd1;
            end else begin
                next_tick = int'(tick_gap) + 1;
                if (next_tick > int'(cfg.timeout_ticks)) begin
                    lost_link = 1'b1;
                    next_tick = 1;
                end
                tick_gap = 5'(next_tick);
            end
            r.speed         = held_speed;
            r.direction     = rotation;
            r.not_connected = lost_link;
            expected_readings.push_back(r);
        endfunction

        function void check_reading(logic [39:0] word);
            reading_t want;
            if (expected_readings.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected result beat %h at %0t", word, $realtime);
                return;
            end
            want = expected_readings.pop_front();
            if (word[31:0] !== want.speed || word[33:32] !== want.direction ||
                word[34] !== want.not_connected) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("mismatch at %0t: speed exp %0d got %0d,",
                             $realtime, $signed(want.speed), $signed(word[31:0]),
                             " dir exp %0d got %0d, nc exp %0b got %0b",
                             want.direction, word[33:32], want.not_connected, word[34]);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [12:0] angle_count, [15:13] zero
    logic [0:0]  s_tuser;   // [0] fresh
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] speed, [33:32] direction, [34] not_connected
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    speed_scoreboard sb;
    logic [11:0]     rx_count;
    int              burst_left;
    int              items_sent;
    int              cur_angle;
    bit              tx_idle_on;

    encoder_window_speed_estimator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result side on a pattern picked by the top two bits of a free-running counter.
    always @(posedge aclk) begin
        rx_count <= rx_count + 12'd1;
        case (rx_count[11:10])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 1) == 1);
            2'd2: m_tready <= (rx_count[1:0] == 2'd0);
            default: m_tready <= (rx_count[5:0] >= 6'd20);
        endcase
    end

    // Check every accepted result beat.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_reading(m_tdata);
    end

    // End the run when no beat moves for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Send one tick; open a new burst with a random gap when the last ran out.
    task automatic send_tick(input bit fresh, input logic [12:0] angle);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = 0;
            if (tx_idle_on)
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 50) : $urandom_range(0, 4);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fresh;
        s_tdata  <= {3'b000, angle};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.predict_tick(fresh, angle);
        burst_left--;
        items_sent++;
    endtask

    // Hold the sender until every owed reading has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.expected_readings.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] word);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, word);
    endtask

    // Write all registers, with junk above each field, plus an unmapped slot.
    task automatic write_config(input logic [23:0] gain, input logic [23:0] enter,
                                input logic [23:0] leave, input logic [15:0] gear,
                                input logic [4:0] tmo);
        logic [31:0] w;
        w = $urandom(); w[23:0] = gain;  apb_write(REG_RATE_GAIN, w);
        w = $urandom(); w[23:0] = enter; apb_write(REG_ENTER_THR, w);
        w = $urandom(); w[23:0] = leave; apb_write(REG_LEAVE_THR, w);
        w = $urandom(); w[15:0] = gear;  apb_write(REG_GEAR_SCALE, w);
        w = $urandom(); w[4:0]  = tmo;   apb_write(REG_TIMEOUT, w);
        apb_write(REG_UNUSED, $urandom());
    endtask

    // Steady rotation: one sample every period ticks, now and then up to two more, vel counts per sample.
    task automatic run_rotation(input int period, input int vel, input int count);
        int idle_ticks;
        for (int i = 0; i < count; i++) begin
            idle_ticks = period - 1;
            if ($urandom_range(0, 7) == 0) idle_ticks += $urandom_range(0, 2);
            repeat (idle_ticks) send_tick(1'b0, 13'($urandom()));
            cur_angle = (cur_angle + vel) & 8191;
            send_tick(1'b1, 13'(cur_angle));
        end
    endtask

    // Fill the whole window with one angle, then step by delta.
    task automatic run_probe(input int base, input int delta);
        repeat (RING_DEPTH) send_tick(1'b1, 13'(base));
        send_tick(1'b1, 13'(base + delta));
        cur_angle = (base + delta) & 8191;
    endtask

    task automatic run_phase(input int target);
        int start, kind, p, v, n;
        start = items_sent;
        while (items_sent - start < target) begin
            kind = $urandom_range(0, 9);
            p = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 3);
            v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6000) : $urandom_range(0, 300);
            v = ($urandom_range(0, 4) == 0) ? v - 3000 : (v % 301) - 150;
            n = $urandom_range(5, 40);
            case (kind)
                0, 1, 2, 3, 4, 5: run_rotation(p, v, n);
                6: begin
                    // reversal through zero
                    run_rotation(p, v, n);
                    run_rotation(p, -v, n);
                end
                7: repeat ($urandom_range(10, 30))
                       send_tick(1'($urandom()), 13'($urandom()));
                8: repeat ($urandom_range(1, 40)) send_tick(1'b0, 13'($urandom()));
                default: run_rotation(p, 0, n);
            endcase
            if ($urandom_range(0, 15) == 0) drain();
        end
    endtask

    initial begin
        logic [23:0] g, e, l;
        logic [15:0] gs;
        logic [4:0]  to;

        sb = new();
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        rx_count   = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        burst_left = 0;
        items_sent = 0;
        cur_angle  = 0;
        tx_idle_on = 1'b1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed ticks on reset defaults: empty gap sum first, angle extremes,
        // downward wrap, an unwrapped step of exactly the limit.
        send_tick(1'b1, 13'd4000);
        send_tick(1'b1, 13'd8191);
        send_tick(1'b1, 13'd0);
        send_tick(1'b0, 13'd8191);
        send_tick(1'b0, 13'd0);
        send_tick(1'b0, 13'd5555);
        send_tick(1'b1, 13'd6000);
        send_tick(1'b0, 13'd1234);
        send_tick(1'b1, 13'd100);
        send_tick(1'b1, 13'd8000);
        send_tick(1'b1, 13'd3);

        // Zero timeout: any tick without a sample raises the flag.
        drain();
        write_config(24'hFF_FFFF, 24'd0, 24'hFF_FFFF, 16'h7FFF, 5'd0);
        send_tick(1'b0, 13'd0);
        send_tick(1'b0, 13'd8191);
        send_tick(1'b1, 13'd8191);
        send_tick(1'b1, 13'd0);
        send_tick(1'b1, 13'd4096);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            case (ph)
                0: write_config(24'hFF_FFFF, 24'd0, 24'd0, 16'h7FFF, 5'd31);
                1: write_config(24'd0, 24'hFF_FFFF, 24'hFF_FFFF, 16'h8000, 5'd1);
                2: write_config(RATE_GAIN_RST, ENTER_THR_RST, LEAVE_THR_RST,
                                GEAR_SCALE_RST, TIMEOUT_RST);
                default: begin
                    g  = ($urandom_range(0, 3) == 0) ? 24'($urandom())
                                                     : 24'($urandom_range(0, 200000));
                    e  = 24'($urandom_range(0, 300000));
                    l  = 24'($urandom_range(0, 300000));
                    gs = 16'($urandom());
                    to = 5'($urandom_range(0, 31));
                    write_config(g, e, l, gs, to);
                end
            endcase
            tx_idle_on = (ph % 3 != 1);
            if (ph == 2) begin
                // window differences right at and just past the wrap limit
                run_probe(1000, 6000);
                run_probe(1000, 6001);
                run_probe(7000, -6000);
                run_probe(7000, -6001);
            end
            run_phase(ITEMS_PER_PHASE);
        end

        drain();
        repeat (60) @(posedge aclk);
        if (sb.expected_readings.size() != 0)
            $display("%0d expected readings never arrived", sb.expected_readings.size());
        if (sb.errors == 0 && sb.expected_readings.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
